// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Types, codes and arithmetic helpers for the palette fade remap block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfr_pkg;

  // Default palette depth.
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int COLOR_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int FRAC_SHIFT  = 7;
  localparam int PROD_W      = 17;
  localparam int SQ_W        = 16;
  localparam int DIST_W      = 18;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_COLOR  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FADE_FRACTION = 2'd1;

  // Request opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_REMAP = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  // Signed product (orig - target) * half, with half below 128.
  function automatic logic signed [PROD_W-1:0] fade_product(
    input logic [COLOR_W-1:0] orig,
    input logic [COLOR_W-1:0] tgt,
    input logic [COLOR_W-2:0] half
  );
    logic signed [COLOR_W:0]   d;
    logic signed [COLOR_W-1:0] h;
    logic signed [PROD_W-1:0]  p;
    d = $signed({1'b0, orig}) - $signed({1'b0, tgt});
    h = $signed({1'b0, half});
    p = d * h;
    return p;
  endfunction

  // Faded component: orig minus floor(prod / 128), modulo 256.
  function automatic logic [COLOR_W-1:0] fade_apply(
    input logic [COLOR_W-1:0]       orig,
    input logic signed [PROD_W-1:0] prod
  );
    return orig - prod[FRAC_SHIFT+COLOR_W-1:FRAC_SHIFT];
  endfunction

  // Squared difference of two components.
  function automatic logic [SQ_W-1:0] sq_diff(
    input logic [COLOR_W-1:0] a,
    input logic [COLOR_W-1:0] b
  );
    logic signed [COLOR_W:0]    d;
    logic signed [2*COLOR_W+1:0] p;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/palette_fade_remap.sv -----
// ----------------------------------------------------------------------------
// palette_fade_remap
// Fades a palette color toward a target color and finds the nearest entry.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_* channel. Opcode write stores red, green
// and blue at entry_index when taken and gives no result. Opcode remap fades
// entry entry_index toward entry target_color by fade_fraction and returns on
// the out_* channel the index asked about and the nearest palette index (1 and
// up, never the index itself, ties to the lowest). Index zero skips the scan
// and returns 0 once the output register is free. Any other index fetches the
// target and the entry, forms the fade products and then the faded color,
// reads one palette entry per cycle over entries 1 to PALETTE_ENTRIES-1,
// drains the scan pipeline and then loads the output register. in_ready stays
// low until then, so no new request is taken while a remap is in progress.
// Indexes at or above PALETTE_ENTRIES are dropped silently. Configuration
// writes on cfg_* are always ready and must only happen while the block is
// idle. Reset clears the control state and both registers; the palette is
// undefined until written. A stalled result waits in the output register;
// writes are still taken, and a remap finishes its scan and then waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_fade_remap #(
  parameter int PALETTE_ENTRIES = pfr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pfr_pkg::COLOR_W-1:0]       cfg_data,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [pfr_pkg::COLOR_W-1:0]       entry_index,
  input  logic [pfr_pkg::COLOR_W-1:0]       red,
  input  logic [pfr_pkg::COLOR_W-1:0]       green,
  input  logic [pfr_pkg::COLOR_W-1:0]       blue,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pfr_pkg::COLOR_W-1:0]       remapped_index,
  output logic [pfr_pkg::COLOR_W-1:0]       remap_color
);

`include "assert_macros.svh"

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = pfr_pkg::COLOR_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TGT    = 3'd1;
  localparam logic [2:0] S_ORIG   = 3'd2;
  localparam logic [2:0] S_FADE   = 3'd3;
  localparam logic [2:0] S_IDEAL  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  localparam logic [AW-1:0] LAST_K = AW'(PALETTE_ENTRIES - 1);

  // Palette memory and its registered read port.
  pfr_pkg::rgb_t mem [PALETTE_ENTRIES];
  pfr_pkg::rgb_t mem_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [2:0]    state;
  logic [CW-1:0] target_color;
  logic [CW-1:0] fade_fraction;

  logic [CW-1:0] req_index;
  logic [AW-1:0] req_addr;
  logic          tgt_in_range;
  pfr_pkg::rgb_t tgt;
  pfr_pkg::rgb_t orig;
  pfr_pkg::rgb_t ideal;
  logic signed [pfr_pkg::PROD_W-1:0] prod_r;
  logic signed [pfr_pkg::PROD_W-1:0] prod_g;
  logic signed [pfr_pkg::PROD_W-1:0] prod_b;

  // Scan pipeline.
  logic [AW-1:0] scan_k;
  logic          s1_valid;
  logic [AW-1:0] s1_k;
  logic          s2_valid;
  logic [AW-1:0] s2_k;
  logic [pfr_pkg::SQ_W-1:0]   sq_r;
  logic [pfr_pkg::SQ_W-1:0]   sq_g;
  logic [pfr_pkg::SQ_W-1:0]   sq_b;
  logic [pfr_pkg::DIST_W-1:0] cand_dist;
  logic                       found;
  logic [pfr_pkg::DIST_W-1:0] best_dist;
  logic [CW-1:0]              best_color;

  logic in_accept;
  logic idx_in_range;
  logic out_load;

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state == S_IDLE);
  assign in_accept    = in_valid && in_ready;
  assign idx_in_range = ({1'b0, entry_index} < (CW+1)'(PALETTE_ENTRIES));
  assign wr_en        = in_accept && (opcode == pfr_pkg::OP_WRITE) && idx_in_range;
  assign out_load     = (state == S_FINISH) && (!out_valid || out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_color  <= '0;
      fade_fraction <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfr_pkg::CFG_TARGET_COLOR:  target_color  <= cfg_data;
        pfr_pkg::CFG_FADE_FRACTION: fade_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read address selection by phase.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_k;
    unique case (state)
      S_TGT: begin
        rd_en   = 1'b1;
        rd_addr = target_color[AW-1:0];
      end
      S_ORIG: begin
        rd_en   = 1'b1;
        rd_addr = req_addr;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_k;
      end
      default: ;
    endcase
  end

  // Palette write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[entry_index[AW-1:0]] <= '{r: red, g: green, b: blue};
    end
  end

  // Palette read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Distance of the candidate in the last pipeline stage.
  assign cand_dist = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept && (opcode == pfr_pkg::OP_REMAP) && idx_in_range) begin
            state <= (entry_index == '0) ? S_FINISH : S_TGT;
          end
        end
        S_TGT:   state <= S_ORIG;
        S_ORIG:  state <= S_FADE;
        S_FADE:  state <= S_IDEAL;
        S_IDEAL: state <= S_SCAN;
        S_SCAN: begin
          if (scan_k == LAST_K) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request datapath: capture, target fetch and fade arithmetic.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_index    <= entry_index;
      req_addr     <= entry_index[AW-1:0];
      tgt_in_range <= ({1'b0, target_color} < (CW+1)'(PALETTE_ENTRIES));
    end
    if (state == S_ORIG) begin
      tgt <= tgt_in_range ? mem_q : '0;
    end
    if (state == S_FADE) begin
      orig   <= mem_q;
      prod_r <= pfr_pkg::fade_product(mem_q.r, tgt.r, fade_fraction[CW-1:1]);
      prod_g <= pfr_pkg::fade_product(mem_q.g, tgt.g, fade_fraction[CW-1:1]);
      prod_b <= pfr_pkg::fade_product(mem_q.b, tgt.b, fade_fraction[CW-1:1]);
    end
    if (state == S_IDEAL) begin
      ideal.r <= pfr_pkg::fade_apply(orig.r, prod_r);
      ideal.g <= pfr_pkg::fade_apply(orig.g, prod_g);
      ideal.b <= pfr_pkg::fade_apply(orig.b, prod_b);
    end
  end

  // Scan counter.
  always_ff @(posedge clk) begin
    if (state == S_IDEAL) begin
      scan_k <= AW'(1);
    end else if (state == S_SCAN) begin
      scan_k <= scan_k + AW'(1);
    end
  end

  // Scan pipeline valid bits; the requested index itself is skipped.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_SCAN) && (scan_k != req_addr);
      s2_valid <= s1_valid;
    end
  end

  // Squared component distances of the entry just read.
  always_ff @(posedge clk) begin
    s1_k <= scan_k;
    s2_k <= s1_k;
    sq_r <= pfr_pkg::sq_diff(mem_q.r, ideal.r);
    sq_g <= pfr_pkg::sq_diff(mem_q.g, ideal.g);
    sq_b <= pfr_pkg::sq_diff(mem_q.b, ideal.b);
  end

  // Running minimum; a strict compare keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == S_IDLE) begin
      found <= 1'b0;
      if (in_accept) begin
        best_color <= '0;
      end
    end else if (state == S_IDEAL) begin
      best_color <= target_color;
    end else if (s2_valid && (!found || (cand_dist < best_dist))) begin
      found      <= 1'b1;
      best_dist  <= cand_dist;
      best_color <= CW'(s2_k);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      remapped_index <= req_index;
      remap_color    <= best_color;
    end
  end

  // Assertions.
  `ASSERT_ALWAYS(a_no_accept_in_scan, clk, rst, !(in_accept && (s1_valid || s2_valid)), "request accepted during scan")
  `ASSERT_ALWAYS(a_scan_nonzero, clk, rst, !((state == S_SCAN) && (scan_k == '0)), "scan reached index zero")
  `ASSERT_NEXT(a_remap_starts, clk, rst, in_accept && (opcode == pfr_pkg::OP_REMAP) && idx_in_range && (entry_index != '0), state == S_TGT, "remap did not start target fetch")
  `ASSERT_NEXT(a_not_self, clk, rst, out_load && (req_index != '0), remap_color != remapped_index, "remap returned its own index")

endmodule

// ----- bench/palette_fade_remap_test.sv -----
// ----------------------------------------------------------------------------
// palette_fade_remap_test
// Self-checking bench for the palette fade remap block. It loads a full
// palette, walks a short table of directed requests, and then runs random
// phases under several fade settings. A behavioral predictor tracks the
// palette and both registers and checks every remap result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_fade_remap_test;

  localparam int COLOR_W        = pfr_pkg::COLOR_W;
  localparam int CFG_INDEX_W    = pfr_pkg::CFG_INDEX_W;
  localparam int FRAC_SHIFT     = pfr_pkg::FRAC_SHIFT;

  localparam int CLK_PERIOD     = 4;
  localparam int PALETTE_DEPTH  = pfr_pkg::PALETTE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES  = PALETTE_DEPTH + 16;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 197;
  localparam int DIRECTED_ROWS  = 28;
  localparam int MAX_REPORTS    = 10;
  localparam longint LIMIT_NS   = 64'd12_000_000;

  // Register indexes that decode to nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct packed {
    logic               op;
    logic [COLOR_W-1:0] idx;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } palette_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] index;
    logic [COLOR_W-1:0] color;
  } remap_result_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [COLOR_W-1:0]     reg_data;
    palette_req_t           req;
    logic                   typed;
    logic [COLOR_W-1:0]     want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]     cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   opcode = pfr_pkg::OP_WRITE;
  logic [COLOR_W-1:0]     entry_index = '0;
  logic [COLOR_W-1:0]     red = '0;
  logic [COLOR_W-1:0]     green = '0;
  logic [COLOR_W-1:0]     blue = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COLOR_W-1:0]     remapped_index;
  logic [COLOR_W-1:0]     remap_color;

  // Predictor state: palette contents and the two registers.
  logic [COLOR_W-1:0] pal_red   [PALETTE_DEPTH];
  logic [COLOR_W-1:0] pal_green [PALETTE_DEPTH];
  logic [COLOR_W-1:0] pal_blue  [PALETTE_DEPTH];
  logic [COLOR_W-1:0] fade_target = '0;
  logic [COLOR_W-1:0] fade_amount = '0;

  remap_result_t awaited_remaps[$];
  remap_result_t oldest_remap;
  int unsigned   mismatch_count = 0;

  // Directed table. Wanted colors are typed in where the answer is plain.
  row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd1, 8'hff, 8'hff, 8'hff}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd2, 8'hff, 8'hff, 8'hff}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd0, 8'hff, 8'hff, 8'hff}, 1'b1, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd1, 8'h00, 8'h00, 8'h00}, 1'b1, 8'd2},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd2, 8'h00, 8'h00, 8'h00}, 1'b1, 8'd1},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, pfr_pkg::CFG_TARGET_COLOR, 8'd1,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, pfr_pkg::CFG_FADE_FRACTION, 8'd255,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd255, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd1, 8'h00, 8'h00, 8'h00}, 1'b1, 8'd2},
    '{ROW_REGISTER, pfr_pkg::CFG_TARGET_COLOR, 8'd255,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, pfr_pkg::CFG_FADE_FRACTION, 8'd1,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd2, 8'h00, 8'h00, 8'h00}, 1'b1, 8'd1},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd3, 8'h00, 8'h80, 8'hff}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd4, 8'hff, 8'h80, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd3, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, pfr_pkg::CFG_FADE_FRACTION, 8'd254,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, pfr_pkg::CFG_TARGET_COLOR, 8'd3,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd4, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, CFG_SPARE_2, 8'hff,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REGISTER, CFG_SPARE_3, 8'h55,
      '{pfr_pkg::OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd128, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_WRITE, 8'd128, 8'h7f, 8'h01, 8'hfe}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd254, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0},
    '{ROW_REQUEST, pfr_pkg::CFG_TARGET_COLOR, 8'h00,
      '{pfr_pkg::OP_REMAP, 8'd128, 8'h00, 8'h00, 8'h00}, 1'b0, 8'd0}
  };

  palette_fade_remap uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .entry_index    (entry_index),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .remapped_index (remapped_index),
    .remap_color    (remap_color)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // One faded component: orig minus floor((orig - toward) * half / 128), mod 256.
  function automatic logic [COLOR_W-1:0] faded_component(
    input logic [COLOR_W-1:0] orig,
    input logic [COLOR_W-1:0] toward,
    input int                 half
  );
    int                 o;
    int                 t;
    int                 prod;
    logic [COLOR_W-1:0] step;
    o = int'(orig);
    t = int'(toward);
    prod = (o - t) * half;
    step = COLOR_W'(prod >>> FRAC_SHIFT);
    return orig - step;
  endfunction

  // Nearest palette entry to the faded color of entry idx.
  function automatic logic [COLOR_W-1:0] predict_remap_color(
    input logic [COLOR_W-1:0] idx
  );
    logic [COLOR_W-1:0] tr;
    logic [COLOR_W-1:0] tg;
    logic [COLOR_W-1:0] tb;
    logic [COLOR_W-1:0] best;
    int                 half;
    int                 ir;
    int                 ig;
    int                 ib;
    int                 dr;
    int                 dg;
    int                 db;
    int                 dist_sum;
    int                 best_dist;
    bit                 found;
    if (idx == '0) begin
      return '0;
    end
    tr = '0;
    tg = '0;
    tb = '0;
    if (int'(fade_target) < PALETTE_DEPTH) begin
      tr = pal_red[fade_target];
      tg = pal_green[fade_target];
      tb = pal_blue[fade_target];
    end
    half = int'(fade_amount >> 1);
    ir = int'(faded_component(pal_red[idx], tr, half));
    ig = int'(faded_component(pal_green[idx], tg, half));
    ib = int'(faded_component(pal_blue[idx], tb, half));
    best = fade_target;
    best_dist = 0;
    found = 1'b0;
    for (int k = 1; k < PALETTE_DEPTH; k++) begin
      if (k != int'(idx)) begin
        dr = int'(pal_red[k]) - ir;
        dg = int'(pal_green[k]) - ig;
        db = int'(pal_blue[k]) - ib;
        dist_sum = dr * dr + dg * dg + db * db;
        if (!found || dist_sum < best_dist) begin
          found = 1'b1;
          best_dist = dist_sum;
          best = COLOR_W'(k);
        end
      end
    end
    return best;
  endfunction

  // Random request. Writes often copy or nudge an existing color to make ties.
  function automatic palette_req_t random_request();
    palette_req_t q;
    int unsigned  pick;
    int unsigned  src;
    q.r = COLOR_W'($urandom_range(255));
    q.g = COLOR_W'($urandom_range(255));
    q.b = COLOR_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 45) begin
      q.op = pfr_pkg::OP_REMAP;
      pick = $urandom_range(99);
      if (pick < 8) begin
        q.idx = '0;
      end else if (pick < 13) begin
        q.idx = 8'd255;
      end else if (pick < 18) begin
        q.idx = 8'd1;
      end else if (pick < 25) begin
        q.idx = fade_target;
      end else begin
        q.idx = COLOR_W'($urandom_range(255));
      end
    end else begin
      q.op = pfr_pkg::OP_WRITE;
      q.idx = COLOR_W'($urandom_range(255));
      src = $urandom_range(1, PALETTE_DEPTH - 1);
      pick = $urandom_range(99);
      if (pick < 30) begin
        q.r = pal_red[src];
        q.g = pal_green[src];
        q.b = pal_blue[src];
      end else if (pick < 45) begin
        q.r = COLOR_W'(pal_red[src] + $urandom_range(6) - 3);
        q.g = COLOR_W'(pal_green[src] + $urandom_range(6) - 3);
        q.b = COLOR_W'(pal_blue[src] + $urandom_range(6) - 3);
      end else if (pick < 60) begin
        q.r = $urandom_range(1) ? 8'hff : 8'h00;
        q.g = $urandom_range(1) ? 8'hff : 8'h00;
        q.b = $urandom_range(1) ? 8'hff : 8'h00;
      end
    end
    return q;
  endfunction

  // Present one request and hold it until taken; valid stays high afterward.
  task automatic push_request(
    input palette_req_t       q,
    input logic               typed,
    input logic [COLOR_W-1:0] want
  );
    remap_result_t due;
    in_valid <= 1'b1;
    opcode <= q.op;
    entry_index <= q.idx;
    red <= q.r;
    green <= q.g;
    blue <= q.b;
    do @(posedge clk); while (!in_ready);
    if (int'(q.idx) < PALETTE_DEPTH) begin
      if (q.op == pfr_pkg::OP_WRITE) begin
        pal_red[q.idx] = q.r;
        pal_green[q.idx] = q.g;
        pal_blue[q.idx] = q.b;
      end else begin
        due.index = q.idx;
        due.color = typed ? want : predict_remap_color(q.idx);
        awaited_remaps.push_back(due);
      end
    end
  endtask

  // Drop valid and wait until every remap has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_remaps.size() != 0);
  endtask

  // Make the block idle before a register write or the end of the run.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(
    input logic [CFG_INDEX_W-1:0] index,
    input logic [COLOR_W-1:0]     data
  );
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      pfr_pkg::CFG_TARGET_COLOR:  fade_target = data;
      pfr_pkg::CFG_FADE_FRACTION: fade_amount = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_mismatch(
    input string              what,
    input logic [COLOR_W-1:0] want,
    input logic [COLOR_W-1:0] got
  );
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Result checker: each taken result against the oldest pending remap.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_remaps.size() == 0) begin
        note_mismatch("unexpected result, remap_color", '0, remap_color);
      end else begin
        oldest_remap = awaited_remaps.pop_front();
        if (remapped_index !== oldest_remap.index) begin
          note_mismatch("remapped_index", oldest_remap.index, remapped_index);
        end
        if (remap_color !== oldest_remap.color) begin
          note_mismatch("remap_color", oldest_remap.color, remap_color);
        end
      end
    end
  end

  // Receiver: random stalls, with calm stretches where it always takes.
  always @(posedge clk) begin : sink_pattern
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned roll;
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm_left != 0) begin
      out_ready <= 1'b1;
      calm_left = calm_left - 1;
    end else begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 60);
      end else begin
        out_ready <= 1'b1;
        if (roll < 5) begin
          calm_left = $urandom_range(200, 2000);
        end
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    palette_req_t       q;
    logic [COLOR_W-1:0] tgt;
    logic [COLOR_W-1:0] frac;
    int                 sent;
    int                 burst;
    int                 burst_no;
    int unsigned        gap;
    int unsigned        roll;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every entry so no remap ever reads an unwritten one.
    for (int e = 0; e < PALETTE_DEPTH; e++) begin
      q.op = pfr_pkg::OP_WRITE;
      q.idx = COLOR_W'(e);
      q.r = COLOR_W'($urandom_range(255));
      q.g = COLOR_W'($urandom_range(255));
      q.b = COLOR_W'($urandom_range(255));
      push_request(q, 1'b0, '0);
    end

    // Directed table.
    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_REGISTER) begin
        settle();
        reg_write(directed_rows[n].reg_index, directed_rows[n].reg_data);
      end else begin
        push_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          tgt = 8'd0;
          frac = 8'd255;
        end
        1: begin
          tgt = 8'd255;
          frac = 8'd0;
        end
        2: begin
          tgt = 8'd128;
          frac = 8'd1;
        end
        3: begin
          tgt = 8'd1;
          frac = 8'd254;
        end
        default: begin
          tgt = COLOR_W'($urandom_range(255));
          frac = COLOR_W'($urandom_range(255));
        end
      endcase
      reg_write(pfr_pkg::CFG_TARGET_COLOR, tgt);
      reg_write(pfr_pkg::CFG_FADE_FRACTION, frac);
      if ($urandom_range(2) == 0) begin
        reg_write($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
                  COLOR_W'($urandom_range(255)));
      end

      sent = 0;
      burst_no = 0;
      while (sent < PHASE_REQUESTS) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst && sent < PHASE_REQUESTS; i++) begin
          push_request(random_request(), 1'b0, '0);
          sent++;
        end
        burst_no++;
        roll = $urandom_range(99);
        if (burst_no == 3 || roll < 4) begin
          hold_until_drained();
        end else begin
          if (roll < 34) begin
            gap = 0;
          end else if (roll < 89) begin
            gap = $urandom_range(1, 6);
          end else if (roll < 96) begin
            gap = $urandom_range(7, 40);
          end else begin
            gap = $urandom_range(300, 400);
          end
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    settle();
    if (mismatch_count == 0 && awaited_remaps.size() == 0) begin
      $display("palette_fade_remap verification clean");
    end else begin
      $display("palette_fade_remap verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_NS);
    $display("palette_fade_remap verification failed");
    $finish;
  end

endmodule

// ----- palette_fade_remap.f -----
+incdir+hw/rtl
hw/rtl/pfr_pkg.sv
hw/rtl/palette_fade_remap.sv
bench/palette_fade_remap_test.sv
